[sv/rpp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the path position core.
package rpp_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_COORD_BITS   = 20;
    localparam int ELAPSED_BITS     = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_LADD,
        S_QPER,
        S_QCHK,
        S_DIV,
        S_WALK,
        S_POS
    } t_state;

endpackage

[sv/rectilinear_path_position_core.sv]
`timescale 1ns / 1ps
// Position along a closed rectilinear path at a given elapsed distance.
// Load item, in order: capture, store vertex, add segment to perimeter.
// Query item, in order after the accept: a perimeter step, a check, a 32-step restoring modulo,
// a walk over the stored segments in turn, and a step to form the point; an empty path or a zero
// perimeter goes straight to forming the point. A stalled output register adds its stall.
// Synchronous active-low reset clears control state, vertex count and perimeter; the
// vertex memory is not cleared and is only read below the vertex count.
module rectilinear_path_position_core #(
    parameter int MAX_VERTICES = rpp_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = rpp_pkg::DEF_COORD_BITS,
    localparam int IN_BITS     = ((2 * COORD_BITS + rpp_pkg::ELAPSED_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [IN_BITS-1:0]  i_s_axis_tdata,   // coord_x, coord_y, elapsed
    input  logic [1:0]          i_s_axis_tuser,   // operation, first_vertex
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OUT_BITS-1:0] o_m_axis_tdata,   // pos_x, pos_y
    output logic [0:0]          o_m_axis_tuser    // status
);
    import rpp_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int PW  = COORD_BITS + 1 + AW;
    localparam int EB  = ELAPSED_BITS;
    localparam int BW  = $clog2(ELAPSED_BITS);
    localparam int LW  = CB + 1;

    function automatic logic [CB-1:0] absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [LW-1:0] seglen(input logic [CB-1:0] ax, input logic [CB-1:0] ay,
                                             input logic [CB-1:0] bx, input logic [CB-1:0] by);
        return {1'b0, absdiff(ax, bx)} + {1'b0, absdiff(ay, by)};
    endfunction

    function automatic logic [CB-1:0] move_toward(input logic [CB-1:0] from,
                                                  input logic [CB-1:0] to,
                                                  input logic [CB-1:0] d);
        return (from > to) ? (from - d) : (from + d);
    endfunction

    t_state r_state, n_state;

    logic [CB-1:0] r_mem_x [MAX_VERTICES];
    logic [CB-1:0] r_mem_y [MAX_VERTICES];
    logic [CB-1:0] r_rd_x, r_rd_y;

    logic          r_op, r_first;
    logic [CB-1:0] r_in_x, r_in_y;
    logic [EB-1:0] r_dvd;

    logic [CW-1:0] r_count;
    logic [PW-1:0] r_open, r_per, r_rem;
    logic [LW-1:0] r_seg;
    logic [CB-1:0] r_fx, r_fy, r_lx, r_ly;
    logic [CB-1:0] r_ax, r_ay, r_bx, r_by;
    logic [BW-1:0] r_bit;
    logic [CW-1:0] r_j;
    logic          r_err;

    logic                r_m_valid;
    logic [CB-1:0]       r_m_x, r_m_y;
    logic                r_m_err;

    logic          w_s_acc, w_out_free;
    logic [CW:0]   n_rd_addr;
    logic [AW-1:0] w_rd_addr;
    logic [CW-1:0] w_eff_cnt;
    logic [PW:0]   w_trial, w_diff;
    logic          w_ge;
    logic          w_last_seg, w_hit;
    logic [CB-1:0] w_bx, w_by;
    logic [LW-1:0] w_len;
    logic [CB-1:0] w_pdx;
    logic [PW-1:0] w_prem;

    assign w_s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_BITS'({r_m_y, r_m_x});
    assign o_m_axis_tuser  = r_m_err;

    assign w_eff_cnt = r_first ? '0 : r_count;

    assign w_trial = {r_rem, r_dvd[EB-1]};
    assign w_diff  = w_trial - {1'b0, r_per};
    assign w_ge    = (w_trial >= {1'b0, r_per});

    assign w_last_seg = (r_j == r_count - 1'b1);
    assign w_bx       = w_last_seg ? r_fx : r_rd_x;
    assign w_by       = w_last_seg ? r_fy : r_rd_y;
    assign w_len      = seglen(r_ax, r_ay, w_bx, w_by);
    assign w_hit      = (r_rem < PW'(w_len));

    assign w_pdx  = absdiff(r_ax, r_bx);
    assign w_prem = r_rem - PW'(w_pdx);

    always_comb begin
        n_state   = r_state;
        n_rd_addr = (CW + 1)'(1);
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_state = (i_s_axis_tuser[0] == OP_QUERY) ? S_QPER : S_LOAD;
                end
            end
            S_LOAD: n_state = S_LADD;
            S_LADD: n_state = S_IDLE;
            S_QPER: n_state = (r_count == '0) ? S_POS : S_QCHK;
            S_QCHK: n_state = (r_per == '0) ? S_POS : S_DIV;
            S_DIV: begin
                if (r_bit == BW'(EB - 1)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_rd_addr = {1'b0, r_j} + (CW + 1)'(2);
                if (w_hit) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_rd_addr = (n_rd_addr < (CW + 1)'(MAX_VERTICES)) ? n_rd_addr[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && w_eff_cnt < CW'(MAX_VERTICES)) begin
            r_mem_x[w_eff_cnt[AW-1:0]] <= r_in_x;
            r_mem_y[w_eff_cnt[AW-1:0]] <= r_in_y;
        end
        r_rd_x <= r_mem_x[w_rd_addr];
        r_rd_y <= r_mem_y[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_open    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_m_axis_tready && r_state != S_POS) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_op    <= i_s_axis_tuser[0];
                        r_first <= i_s_axis_tuser[1];
                        r_in_x  <= i_s_axis_tdata[CB-1:0];
                        r_in_y  <= i_s_axis_tdata[2*CB-1:CB];
                        r_dvd   <= i_s_axis_tdata[2*CB+EB-1:2*CB];
                    end
                end
                S_LOAD: begin
                    r_seg <= '0;
                    if (r_first) begin
                        r_open <= '0;
                    end
                    if (w_eff_cnt < CW'(MAX_VERTICES)) begin
                        r_count <= w_eff_cnt + 1'b1;
                        r_lx    <= r_in_x;
                        r_ly    <= r_in_y;
                        if (w_eff_cnt == '0) begin
                            r_fx <= r_in_x;
                            r_fy <= r_in_y;
                        end else begin
                            r_seg <= seglen(r_lx, r_ly, r_in_x, r_in_y);
                        end
                    end
                end
                S_LADD: r_open <= r_open + PW'(r_seg);
                S_QPER: begin
                    r_per <= r_open + PW'(seglen(r_lx, r_ly, r_fx, r_fy));
                    r_err <= (r_count == '0);
                end
                S_QCHK: begin
                    r_err <= (r_per == '0);
                    r_rem <= '0;
                    r_bit <= '0;
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
                    r_dvd <= {r_dvd[EB-2:0], 1'b0};
                    r_bit <= r_bit + 1'b1;
                    r_j   <= '0;
                    r_ax  <= r_fx;
                    r_ay  <= r_fy;
                end
                S_WALK: begin
                    if (w_hit) begin
                        r_bx <= w_bx;
                        r_by <= w_by;
                    end else begin
                        r_rem <= r_rem - PW'(w_len);
                        r_ax  <= w_bx;
                        r_ay  <= w_by;
                        r_j   <= r_j + 1'b1;
                    end
                end
                S_POS: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_err   <= r_err ? STATUS_ERR : STATUS_OK;
                        if (r_err) begin
                            r_m_x <= '0;
                            r_m_y <= '0;
                        end else if (r_rem < PW'(w_pdx)) begin
                            r_m_x <= move_toward(r_ax, r_bx, r_rem[CB-1:0]);
                            r_m_y <= r_ay;
                        end else begin
                            r_m_x <= r_bx;
                            r_m_y <= move_toward(r_ay, r_by, w_prem[CB-1:0]);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_j < r_count))
        else $error("segment walk ran past the last segment");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_err == STATUS_ERR) |-> (r_m_x == '0 && r_m_y == '0))
        else $error("error result with non-zero position");

    a_query_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QPER) |-> (r_op == OP_QUERY))
        else $error("query path entered for a load item");

endmodule
